// File: sv/wsfe_pkg.sv
package wsfe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int RATE_W    = 16;
    localparam int WIN_DEPTH = 1024;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int IDX_W     = 32;
    localparam int VEL_W     = 33;
    localparam int ACC_W     = 50;
    localparam int PKC_W     = 10;
    localparam int SUM_W     = 26;
    localparam int VAR_W     = 51;
    localparam int SQ_W      = 2 * SAMPLE_W - 1;
    localparam int SQSUM_W   = SQ_W + WIN_AW;
    localparam int PK_W      = WIN_AW + 1;
    localparam int RATE2_W   = 2 * RATE_W;
    localparam int D1_W      = SAMPLE_W + 1;
    localparam int D2_W      = SAMPLE_W + 3;
    localparam int MUL_A_W   = RATE2_W + 1;
    localparam int MUL_B_W   = SUM_W;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_P1,
        S_RD_P2,
        S_RD_N1,
        S_RD_N2,
        S_WRITE,
        S_ACC,
        S_VAR,
        S_OUT
    } t_state;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [WIN_AW-1:0] addr;
        t_sample           wdata;
    } t_mem_req;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    typedef struct packed {
        logic    upd;
        t_sample x;
        t_sample old;
        t_sample p1;
        t_sample p2;
        t_sample n1;
        t_sample n2;
    } t_pk_in;

endpackage

// File: sv/wsfe_if.sv
interface wsfe_sample_if;
    import wsfe_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface wsfe_result_if;
    import wsfe_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         sample_index;
    logic signed [VEL_W-1:0]  velocity;
    logic signed [ACC_W-1:0]  acceleration;
    logic [PKC_W-1:0]         peak_count;
    logic signed [SUM_W-1:0]  window_sum;
    logic [VAR_W-1:0]         variance_numerator;
    modport source (output valid, output sample_index, output velocity, output acceleration,
                    output peak_count, output window_sum, output variance_numerator,
                    input ready);
    modport sink (input valid, input sample_index, input velocity, input acceleration,
                  input peak_count, input window_sum, input variance_numerator,
                  output ready);
endinterface

interface wsfe_cfg_if;
    import wsfe_pkg::*;
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] rate_word;
    modport source (output valid, output rate_word, input ready);
    modport sink (input valid, input rate_word, output ready);
endinterface

// File: sv/window_signal_feature_extractor.sv
// Channel    Dir  Payload                                             Handshake
// i_sample   in   sample_value                                        valid/ready
// o_result   out  sample_index, velocity, acceleration, peak_count,   valid/ready
//                 window_sum, variance_numerator
// i_cfg      in   sample rate                                         valid/ready
//
// Each request goes from acceptance to a loaded result through five reads of the
// single-port window memory and six products through one shared multiplier.
// The next request is accepted in the cycle after the result register is loaded, so
// no request is taken before the last is done. Reset is synchronous; the window reads
// as zero until written, tracked by a fill count, so no clearing pass is needed.
// A stalled result holds the block in its last step until the result register is free.
module window_signal_feature_extractor (
    input logic          i_clk,
    input logic          i_rst_n,
    wsfe_sample_if.sink  i_sample,
    wsfe_result_if.source o_result,
    wsfe_cfg_if.sink     i_cfg
);
    import wsfe_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [RATE_W-1:0]         r_rate;
    t_sample                   r_x;
    t_sample                   r_old;
    t_sample                   r_p1;
    t_sample                   r_p2;
    t_sample                   r_n1;
    t_sample                   r_n2;
    logic [WIN_AW-1:0]         r_pos;
    logic [WIN_AW-1:0]         r_wptr;
    logic [IDX_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic [SQ_W-1:0]           r_sqx;
    logic [RATE2_W-1:0]        r_rate2;
    logic signed [SUM_W-1:0]   r_sum;
    logic [SQSUM_W-1:0]        r_sqsum;
    logic signed [D1_W-1:0]    r_d1;
    logic signed [D2_W-1:0]    r_d2;
    logic signed [VEL_W-1:0]   r_vel;
    logic signed [ACC_W-1:0]   r_acc;
    logic [VAR_W-1:0]          r_var;
    logic                      r_ovalid;
    logic [IDX_W-1:0]          r_res_idx;
    logic signed [VEL_W-1:0]   r_res_vel;
    logic signed [ACC_W-1:0]   r_res_acc;
    logic [PKC_W-1:0]          r_res_pkc;
    logic signed [SUM_W-1:0]   r_res_sum;
    logic [VAR_W-1:0]          r_res_var;

    t_mem_req                  mem_req;
    t_mul_op                   mul_op;
    t_pk_in                    pk_in;
    t_sample                   rd_data;
    logic signed [MUL_P_W-1:0] prod;
    logic [PKC_W-1:0]          pk_count;
    logic                      in_accept;
    logic                      out_free;

    wsfe_win_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_rdata (rd_data)
    );

    wsfe_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    wsfe_peak u_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_nb    (pk_in),
        .o_count (pk_count)
    );

    assign in_accept      = i_sample.valid && i_sample.ready;
    assign out_free       = !r_ovalid || o_result.ready;
    assign i_sample.ready = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;

    assign pk_in.upd = (r_state == S_ACC);
    assign pk_in.x   = r_x;
    assign pk_in.old = r_old;
    assign pk_in.p1  = r_p1;
    assign pk_in.p2  = r_p2;
    assign pk_in.n1  = r_n1;
    assign pk_in.n2  = r_n2;

    always_comb begin
        n_state       = r_state;
        mem_req       = '0;
        mem_req.addr  = r_pos;
        mem_req.wdata = r_x;
        mul_op        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_sample.valid) begin
                    n_state = S_RD_OLD;
                end
            end
            S_RD_OLD: begin
                mem_req.rd = 1'b1;
                mul_op.a   = MUL_A_W'(r_x);
                mul_op.b   = MUL_B_W'(r_x);
                n_state    = S_RD_P1;
            end
            S_RD_P1: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = r_pos - WIN_AW'(1);
                mul_op.a     = MUL_A_W'(r_rate);
                mul_op.b     = MUL_B_W'(r_rate);
                n_state      = S_RD_P2;
            end
            S_RD_P2: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = r_pos - WIN_AW'(2);
                mul_op.a     = MUL_A_W'(r_old);
                mul_op.b     = MUL_B_W'(r_old);
                n_state      = S_RD_N1;
            end
            S_RD_N1: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = r_pos + WIN_AW'(1);
                n_state      = S_RD_N2;
            end
            S_RD_N2: begin
                mem_req.rd   = 1'b1;
                mem_req.addr = r_pos + WIN_AW'(2);
                mul_op.a     = MUL_A_W'(r_d1);
                mul_op.b     = MUL_B_W'(r_rate);
                n_state      = S_WRITE;
            end
            S_WRITE: begin
                mem_req.wr = 1'b1;
                mul_op.a   = MUL_A_W'(r_rate2);
                mul_op.b   = MUL_B_W'(r_d2);
                n_state    = S_ACC;
            end
            S_ACC: begin
                mul_op.a = MUL_A_W'(r_sum);
                mul_op.b = MUL_B_W'(r_sum);
                n_state  = S_VAR;
            end
            S_VAR: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rate   <= RATE_RESET;
            r_wptr   <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_rate <= i_cfg.rate_word;
            end
            if (r_state == S_RD_N1) begin
                r_sum   <= r_sum + SUM_W'(r_x) - SUM_W'(r_old);
                r_sqsum <= r_sqsum + SQSUM_W'(r_sqx) - SQSUM_W'(prod[SQ_W-1:0]);
            end
            if (r_state == S_WRITE) begin
                r_wptr <= r_pos + WIN_AW'(1);
                r_cnt  <= r_cnt + IDX_W'(1);
            end
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_x   <= i_sample.sample_value;
                    r_pos <= r_wptr;
                    r_idx <= r_cnt;
                end
            end
            S_RD_P1: begin
                r_old <= rd_data;
                r_sqx <= prod[SQ_W-1:0];
            end
            S_RD_P2: begin
                r_p1    <= rd_data;
                r_rate2 <= prod[RATE2_W-1:0];
            end
            S_RD_N1: begin
                r_p2 <= rd_data;
                r_d1 <= D1_W'(r_x) - D1_W'(r_p1);
            end
            S_RD_N2: begin
                r_n1 <= rd_data;
                r_d2 <= D2_W'(r_x) - (D2_W'(r_p1) <<< 1) + D2_W'(r_p2);
            end
            S_WRITE: begin
                r_n2  <= rd_data;
                r_vel <= prod[VEL_W-1:0];
            end
            S_ACC: begin
                r_acc <= prod[ACC_W-1:0];
            end
            S_VAR: begin
                r_var <= (VAR_W'(r_sqsum) << WIN_AW) - prod[VAR_W-1:0];
            end
            S_OUT: begin
                if (out_free) begin
                    r_res_idx <= r_idx;
                    r_res_vel <= r_vel;
                    r_res_acc <= r_acc;
                    r_res_pkc <= pk_count;
                    r_res_sum <= r_sum;
                    r_res_var <= r_var;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid              = r_ovalid;
    assign o_result.sample_index       = r_res_idx;
    assign o_result.velocity           = r_res_vel;
    assign o_result.acceleration       = r_res_acc;
    assign o_result.peak_count         = r_res_pkc;
    assign o_result.window_sum         = r_res_sum;
    assign o_result.variance_numerator = r_res_var;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !i_sample.ready)
        else $error("input taken again right after a request");

    a_pointer_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_wptr == ($past(r_pos) + WIN_AW'(1))))
        else $error("write pointer did not advance past the written entry");

    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> (o_result.sample_index == (r_cnt - IDX_W'(1))))
        else $error("result index does not match the sample count");

    a_load_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !r_ovalid) |=> (r_ovalid && (r_state == S_IDLE)))
        else $error("finished result not loaded into an empty output register");

endmodule

// File: sv/wsfe_win_mem.sv
module wsfe_win_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wsfe_pkg::t_mem_req i_req,
    output wsfe_pkg::t_sample  o_rdata
);
    import wsfe_pkg::*;

    t_sample         r_mem [WIN_DEPTH];
    t_sample         r_rdata;
    logic            r_rvld;
    logic [WIN_AW:0] r_fill;
    logic            addr_hit;

    // Writes arrive in address order from zero, so entries at or above the fill count
    // have not been written since reset and read as zero.
    assign addr_hit = ({1'b0, i_req.addr} < r_fill);

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_req.rd) begin
                r_rvld <= addr_hit;
            end
            if (i_req.wr && ({1'b0, i_req.addr} == r_fill)) begin
                r_fill <= r_fill + (WIN_AW + 1)'(1);
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// File: sv/wsfe_mul.sv
module wsfe_mul (
    input  logic                                i_clk,
    input  wsfe_pkg::t_mul_op                   i_op,
    output logic signed [wsfe_pkg::MUL_P_W-1:0] o_prod
);
    import wsfe_pkg::*;

    logic signed [MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(i_op.a) * $signed(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

// File: sv/wsfe_peak.sv
module wsfe_peak (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wsfe_pkg::t_pk_in             i_nb,
    output logic [wsfe_pkg::PKC_W-1:0]   o_count
);
    import wsfe_pkg::*;

    logic [PK_W-1:0]  r_total;
    logic [PK_W-1:0]  n_total;
    logic [PK_W-1:0]  n_count;
    logic [PKC_W-1:0] r_count;
    logic             was_m1;
    logic             was_0;
    logic             was_p1;
    logic             now_m1;
    logic             now_0;
    logic             now_p1;

    // Only the written position and its two neighbors can change peak status.
    always_comb begin
        was_m1 = ($signed(i_nb.p1) > $signed(i_nb.p2)) && ($signed(i_nb.p1) > $signed(i_nb.old));
        was_0  = ($signed(i_nb.old) > $signed(i_nb.p1)) && ($signed(i_nb.old) > $signed(i_nb.n1));
        was_p1 = ($signed(i_nb.n1) > $signed(i_nb.old)) && ($signed(i_nb.n1) > $signed(i_nb.n2));
        now_m1 = ($signed(i_nb.p1) > $signed(i_nb.p2)) && ($signed(i_nb.p1) > $signed(i_nb.x));
        now_0  = ($signed(i_nb.x) > $signed(i_nb.p1)) && ($signed(i_nb.x) > $signed(i_nb.n1));
        now_p1 = ($signed(i_nb.n1) > $signed(i_nb.x)) && ($signed(i_nb.n1) > $signed(i_nb.n2));
        n_total = r_total - PK_W'(was_m1) - PK_W'(was_0) - PK_W'(was_p1)
                + PK_W'(now_m1) + PK_W'(now_0) + PK_W'(now_p1);
        // The newest and the oldest positions are left out of the reported count.
        n_count = n_total - PK_W'(now_0) - PK_W'(now_p1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_nb.upd) begin
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_nb.upd) begin
            r_count <= n_count[PKC_W-1:0];
        end
    end

    assign o_count = r_count;

endmodule

// File: sim/wsfe_feature_checker.sv
module wsfe_feature_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    wsfe_sample_if i_sample,
    wsfe_result_if i_result,
    wsfe_cfg_if    i_cfg,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import wsfe_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]        index;
        logic signed [VEL_W-1:0] velocity;
        logic signed [ACC_W-1:0] acceleration;
        logic [PKC_W-1:0]        peaks;
        logic signed [SUM_W-1:0] sum;
        logic [VAR_W-1:0]        spread;
    } t_feature;

    t_feature          expected_features[$];
    t_sample           window_mem [WIN_DEPTH];
    int                write_slot;
    logic [IDX_W-1:0]  samples_seen;
    longint            window_total;
    longint            square_total;
    logic [RATE_W-1:0] rate;

    task automatic predict_features(input t_sample x, output t_feature f);
        longint old_value;
        longint prev1;
        longint prev2;
        longint diff1;
        longint diff2;
        longint rate_sq;
        int     slot;
        int     idx;
        int     lft;
        int     rgt;
        int     peaks;
        slot = write_slot;
        old_value = longint'(window_mem[slot]);
        window_mem[slot] = x;
        window_total += longint'(x) - old_value;
        square_total += longint'(x) * longint'(x) - old_value * old_value;
        prev1 = longint'(window_mem[(slot + WIN_DEPTH - 1) % WIN_DEPTH]);
        prev2 = longint'(window_mem[(slot + WIN_DEPTH - 2) % WIN_DEPTH]);
        diff1 = longint'(x) - prev1;
        diff2 = longint'(x) - 2 * prev1 + prev2;
        rate_sq = longint'(rate) * longint'(rate);
        // The newest entry and the oldest one, just after it, are left out.
        peaks = 0;
        idx = slot;
        for (int i = 1; i < WIN_DEPTH - 1; i++) begin
            idx = (idx + WIN_DEPTH - 1) % WIN_DEPTH;
            lft = (idx + WIN_DEPTH - 1) % WIN_DEPTH;
            rgt = (idx + 1) % WIN_DEPTH;
            if (window_mem[idx] > window_mem[lft] && window_mem[idx] > window_mem[rgt]) begin
                peaks++;
            end
        end
        f.index        = samples_seen;
        f.velocity     = VEL_W'(diff1 * longint'(rate));
        f.acceleration = ACC_W'(diff2 * rate_sq);
        f.peaks        = PKC_W'(peaks);
        f.sum          = SUM_W'(window_total);
        f.spread       = VAR_W'(longint'(WIN_DEPTH) * square_total
                                - window_total * window_total);
        write_slot = (slot + 1) % WIN_DEPTH;
        samples_seen = samples_seen + IDX_W'(1);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_feature want;
        t_feature fresh;
        if (!i_rst_n) begin
            foreach (window_mem[i]) window_mem[i] = '0;
            write_slot = 0;
            samples_seen = '0;
            window_total = 0;
            square_total = 0;
            rate = RATE_RESET;
            o_errors = 0;
            expected_features.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                rate = i_cfg.rate_word;
            end
            if (i_result.valid && i_result.ready) begin
                if (expected_features.size() == 0) begin
                    $display("%0t: result with index %0d arrived with no request pending",
                             $time, i_result.sample_index);
                    o_errors++;
                end else begin
                    want = expected_features.pop_front();
                    compare_field("sample_index", longint'(want.index),
                                  longint'(i_result.sample_index));
                    compare_field("velocity", longint'(want.velocity),
                                  longint'(i_result.velocity));
                    compare_field("acceleration", longint'(want.acceleration),
                                  longint'(i_result.acceleration));
                    compare_field("peak_count", longint'(want.peaks),
                                  longint'(i_result.peak_count));
                    compare_field("window_sum", longint'(want.sum),
                                  longint'(i_result.window_sum));
                    compare_field("variance_numerator", longint'(want.spread),
                                  longint'(i_result.variance_numerator));
                end
            end
            if (i_sample.valid && i_sample.ready) begin
                predict_features(i_sample.sample_value, fresh);
                expected_features.push_back(fresh);
            end
        end
        o_pending = expected_features.size();
    end

endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfe_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 254;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam t_sample EDGE_SAMPLES [21] = '{
        SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 16'sd0, -16'sd1, 16'sd1, -16'sd1, 16'sd1,
        16'sd0, 16'sd100, 16'sd100, 16'sd100, 16'sd5, 16'sd50, 16'sd5,
        SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 16'sh5555, 16'shaaaa
    };

    typedef enum {
        MODE_UNIFORM,
        MODE_EXTREME,
        MODE_WALK,
        MODE_HOLD,
        MODE_NEAR_ZERO,
        MODE_ONE_BIT
    } t_sample_mode;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic hold_request = 1'b0;
    int   errors;
    int   pending;
    int   items_sent = 0;
    int   rate_writes = 0;
    int   quiet_cycles = 0;

    wsfe_sample_if sample_ch ();
    wsfe_result_if result_ch ();
    wsfe_cfg_if    cfg_ch ();

    window_signal_feature_extractor DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    wsfe_feature_checker checker_inst (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_sample  (sample_ch),
        .i_result  (result_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(input t_sample value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample_value <= value;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // The rate is only changed once every request has come back.
    task automatic write_rate(input logic [RATE_W-1:0] rate);
        sample_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.rate_word <= rate;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        rate_writes++;
    endtask

    initial begin : result_sink
        bit hold_done;
        hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                result_ch.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if ($urandom_range(0, 99) < 60) begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 200)
                                                  : $urandom_range(0, 12)) @(negedge clk);
            end else begin
                result_ch.ready <= 1'b0;
                repeat (pick_gap()) @(negedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= IDLE_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL window_signal_feature_extractor");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        t_sample_mode mode;
        int           prev;
        int           value;
        int           burst;
        int           pick;
        t_sample      next_sample;
        sample_ch.valid <= 1'b0;
        sample_ch.sample_value <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.rate_word <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (EDGE_SAMPLES[i]) send_sample(EDGE_SAMPLES[i]);
        write_rate('1);
        for (int i = 0; i < 4; i++) send_sample(i % 2 == 0 ? SAMPLE_MAX : SAMPLE_MIN);

        prev = 0;
        burst = 0;
        mode = MODE_UNIFORM;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_rate('0);
                1:       write_rate(RATE_W'(1));
                2:       write_rate(RATE_W'($urandom_range(2, 65534)));
                3:       write_rate('1);
                4:       write_rate(RATE_RESET);
                default: write_rate(RATE_W'($urandom_range(2, 100)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst == 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3) begin
                        mode = MODE_WALK;
                    end else if (pick < 6) begin
                        mode = MODE_UNIFORM;
                    end else if (pick == 6) begin
                        mode = MODE_EXTREME;
                    end else if (pick == 7) begin
                        mode = MODE_HOLD;
                    end else if (pick == 8) begin
                        mode = MODE_NEAR_ZERO;
                    end else begin
                        mode = MODE_ONE_BIT;
                    end
                    burst = $urandom_range(1, 40);
                end
                burst--;
                case (mode)
                    MODE_UNIFORM:   value = $urandom_range(0, 65535);
                    MODE_EXTREME:   value = $urandom_range(0, 1) ? 32767 : -32768;
                    MODE_WALK: begin
                        value = prev + int'($urandom_range(0, 2000)) - 1000;
                        if (value > 32767) value = 32767;
                        if (value < -32768) value = -32768;
                    end
                    MODE_HOLD:      value = prev;
                    MODE_NEAR_ZERO: value = int'($urandom_range(0, 8)) - 4;
                    default: begin
                        value = 1 << $urandom_range(0, SAMPLE_W - 1);
                        if ($urandom_range(0, 1)) value = -value;
                    end
                endcase
                next_sample = t_sample'(value);
                prev = int'(next_sample);
                if (phase == 1 && n == 60) hold_request = 1'b1;
                send_sample(next_sample);
            end
        end
        sample_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d samples under %0d sample rates, among them 0, 1 and 65535.",
                 items_sent, rate_writes + 1);
        $display("The %0d-entry window wrapped, and the result side held off %0d cycles once.",
                 WIN_DEPTH, HOLD_CYCLES);
        if (errors == 0) begin
            $display("PASS window_signal_feature_extractor");
        end else begin
            $display("FAIL window_signal_feature_extractor");
        end
        $finish;
    end

endmodule
